>>> rtl/lsf_pkg.sv
`timescale 1ns / 1ps
package lsf_pkg;

  localparam int CNT_W = 32;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_EOF  = 1'b1;

  localparam logic KIND_LINE  = 1'b0;
  localparam logic KIND_COUNT = 1'b1;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int PAT_BYTES  = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_PATTERN_LOW      = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PATTERN_MID_LOW  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_PATTERN_MID_HIGH = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_PATTERN_HIGH     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_PATTERN_LENGTH   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_FOLD_EN          = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_INVERT_SEL       = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_COUNT_MODE       = 3'd7;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic             report_kind;
    logic [CNT_W-1:0] line_num;
    logic [CNT_W-1:0] selected_count;
    logic             last_of_run;
  } report_t;

  typedef struct packed {
    logic [PAT_BYTES*8-1:0] pattern;
    logic [5:0]             pattern_length;
    logic                   fold_en;
    logic                   invert_sel;
    logic                   count_mode;
  } cfg_t;

  // line event handed from the front to the back
  typedef struct packed {
    logic finish;
    logic selected;
    logic eof;
    logic count_mode;
  } cmd_t;

  function automatic logic [7:0] fold_case(input logic [7:0] b, input logic ic);
    if (ic && b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
      return b + CASE_OFFSET;
    end
    return b;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

>>> rtl/lsf_front.sv
`timescale 1ns / 1ps
module lsf_front import lsf_pkg::*; #(
  parameter int MAX_PATTERN = 32,
  parameter int MAX_LINE    = 4096
) (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  item_valid,
  input  item_t item,
  output logic  item_ready,
  output logic  push,
  output cmd_t  cmd,
  input  logic  push_ready
);

  localparam int LW  = $clog2(MAX_PATTERN + 1);
  localparam int WIW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int BW  = $clog2(MAX_LINE);
  localparam int CW  = (BW + 1 > LW) ? BW + 1 : LW;

  logic [7:0]    window [MAX_PATTERN];
  logic [7:0]    window_shift [MAX_PATTERN];
  logic [BW-1:0] bytes_in_line;
  logic          found;
  logic          zero_seen;

  logic          accept;
  logic          is_data;
  logic          shift_en;
  logic [LW-1:0] eff_len;
  logic          eq;
  logic          hit;
  logic          found_now;
  logic [BW-1:0] bil_inc;
  logic          line_end;
  logic          selected;

  assign item_ready = push_ready;
  assign accept     = item_valid && item_ready;
  assign is_data    = (item.op == OP_DATA);
  assign shift_en   = is_data && !zero_seen && (item.data_byte != CHAR_NUL);

  // effective length: clamp, then cut at the first zero pattern byte
  always_comb begin : eff_len_calc
    logic [LW-1:0] lim;
    if (cfg.pattern_length > 6'(MAX_PATTERN)) begin
      lim = LW'(MAX_PATTERN);
    end else begin
      lim = LW'(cfg.pattern_length);
    end
    eff_len = lim;
    for (int i = MAX_PATTERN - 1; i >= 0; i--) begin
      if (LW'(i) < lim && cfg.pattern[i*8 +: 8] == CHAR_NUL) begin
        eff_len = LW'(i);
      end
    end
  end

  always_comb begin
    window_shift[0] = item.data_byte;
    for (int j = 1; j < MAX_PATTERN; j++) begin
      window_shift[j] = window[j-1];
    end
  end

  // pattern byte i lines up with window slot len-1-i
  always_comb begin : window_compare
    logic [LW-1:0] idx;
    eq = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      idx = eff_len - LW'(i) - LW'(1);
      if (LW'(i) < eff_len) begin
        if (fold_case(cfg.pattern[i*8 +: 8], cfg.fold_en) !=
            fold_case(window_shift[idx[WIW-1:0]], cfg.fold_en)) begin
          eq = 1'b0;
        end
      end
    end
  end

  assign hit = shift_en && (eff_len != '0) &&
               ((CW'(bytes_in_line) + CW'(1)) >= CW'(eff_len)) && eq;
  assign found_now = found || hit;
  assign bil_inc   = bytes_in_line + BW'(1);
  assign line_end  = (item.data_byte == CHAR_NEWLINE) || (bil_inc == BW'(MAX_LINE - 1));
  assign selected  = (found_now || (eff_len == '0)) ^ cfg.invert_sel;

  assign push           = accept && (!is_data || line_end);
  assign cmd.finish     = is_data ? 1'b1 : (bytes_in_line != '0);
  assign cmd.selected   = selected;
  assign cmd.eof        = !is_data;
  assign cmd.count_mode = cfg.count_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_in_line <= '0;
      found         <= 1'b0;
      zero_seen     <= 1'b0;
    end else if (accept) begin
      if (!is_data || line_end) begin
        bytes_in_line <= '0;
        found         <= 1'b0;
        zero_seen     <= 1'b0;
      end else begin
        bytes_in_line <= bil_inc;
        found         <= found_now;
        zero_seen     <= zero_seen || (item.data_byte == CHAR_NUL);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && shift_en) begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
        window[j] <= window_shift[j];
      end
    end
  end

endmodule

>>> rtl/lsf_queue.sv
`timescale 1ns / 1ps
module lsf_queue import lsf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic push_ready,
  output logic pop_valid,
  output cmd_t pop_data,
  input  logic pop
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);
  localparam int NW    = $clog2(DEPTH + 1);

  cmd_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] fill;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (fill != NW'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + NW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

>>> rtl/lsf_back.sv
`timescale 1ns / 1ps
module lsf_back import lsf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    cmd_valid,
  input  cmd_t    cmd,
  output logic    cmd_pop,
  output logic    report_valid,
  input  logic    report_ready,
  output report_t report
);

  logic [CNT_W-1:0] line_counter;
  logic [CNT_W-1:0] match_counter;
  logic [CNT_W-1:0] line_counter_next;
  logic [CNT_W-1:0] match_counter_next;
  logic             emit_line;
  logic             emit_count;

  assign cmd_pop = cmd_valid && (!report_valid || report_ready);

  assign line_counter_next  = cmd.finish ? sat_inc(line_counter) : line_counter;
  assign match_counter_next = (cmd.finish && cmd.selected) ? sat_inc(match_counter)
                                                           : match_counter;
  assign emit_line  = cmd.finish && cmd.selected && !cmd.count_mode;
  assign emit_count = cmd.eof && cmd.count_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      report_valid  <= 1'b0;
      line_counter  <= '0;
      match_counter <= '0;
    end else if (cmd_pop) begin
      report_valid <= emit_line || emit_count;
      if (cmd.eof) begin
        line_counter  <= '0;
        match_counter <= '0;
      end else begin
        line_counter  <= line_counter_next;
        match_counter <= match_counter_next;
      end
    end else if (report_ready) begin
      report_valid <= 1'b0;
    end
  end

  // each request yields at most one report, so it is always the last
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      report.report_kind    <= emit_count ? KIND_COUNT : KIND_LINE;
      report.line_num       <= line_counter_next;
      report.selected_count <= match_counter_next;
      report.last_of_run    <= 1'b1;
    end
  end

endmodule

>>> rtl/line_substring_filter.sv
`timescale 1ns / 1ps
// channel   | handshake                  | payload
// item      | item_valid / item_ready    | item (op, data_byte)
// report    | report_valid / report_ready| report (kind, line, count, last)
// config    | cfg_we                     | cfg_addr, cfg_wdata
//
// one request per cycle while the line queue has room, set by the combinational window
// compare; a report is registered after the request that ends its line is taken, passing
// first through the four-entry line queue and then the output register
// reset is synchronous; no clearing pass
// the item side stalls only when the line queue is full, which happens when
// report_ready stays low for several line ends
module line_substring_filter import lsf_pkg::*; #(
  parameter int MAX_PATTERN = 32,
  parameter int MAX_LINE    = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  item_t                 item,
  output logic                  report_valid,
  input  logic                  report_ready,
  output report_t               report,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg;
  logic push;
  cmd_t push_cmd;
  logic push_ready;
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_PATTERN_LOW:      cfg.pattern[63:0]    <= cfg_wdata;
        REG_PATTERN_MID_LOW:  cfg.pattern[127:64]  <= cfg_wdata;
        REG_PATTERN_MID_HIGH: cfg.pattern[191:128] <= cfg_wdata;
        REG_PATTERN_HIGH:     cfg.pattern[255:192] <= cfg_wdata;
        REG_PATTERN_LENGTH:   cfg.pattern_length   <= cfg_wdata[5:0];
        REG_FOLD_EN:          cfg.fold_en          <= cfg_wdata[0];
        REG_INVERT_SEL:       cfg.invert_sel       <= cfg_wdata[0];
        REG_COUNT_MODE:       cfg.count_mode       <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  lsf_front #(
    .MAX_PATTERN (MAX_PATTERN),
    .MAX_LINE    (MAX_LINE)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready),
    .push       (push),
    .cmd        (push_cmd),
    .push_ready (push_ready)
  );

  lsf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_data   (q_cmd),
    .pop        (q_pop)
  );

  lsf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (q_valid),
    .cmd          (q_cmd),
    .cmd_pop      (q_pop),
    .report_valid (report_valid),
    .report_ready (report_ready),
    .report       (report)
  );

endmodule

>>> rtl/lsf_checker.sv
`timescale 1ns / 1ps
module lsf_checker import lsf_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    report_valid,
  input logic    report_ready,
  input report_t report
);

  // nothing is left in flight once reset has been applied
  a_reset_clears: assert property (@(posedge clk) rst |=> !report_valid)
    else $error("report valid right after reset");

  a_report_holds: assert property (@(posedge clk) disable iff (rst)
    report_valid && !report_ready |=> report_valid && $stable(report))
    else $error("stalled report changed");

  // every request causes at most one report
  a_single_report: assert property (@(posedge clk) disable iff (rst)
    report_valid |-> report.last_of_run)
    else $error("report not marked last");

  // a line report always follows a counted, selected line
  a_line_counts: assert property (@(posedge clk) disable iff (rst)
    report_valid && report.report_kind == KIND_LINE |->
      report.line_num != '0 && report.selected_count != '0)
    else $error("line report with zero counter");

  // selected lines can never outnumber lines
  a_count_order: assert property (@(posedge clk) disable iff (rst)
    report_valid |-> report.selected_count <= report.line_num)
    else $error("selected count above line count");

endmodule

bind line_substring_filter lsf_checker u_lsf_checker (.*);
